### hw/rtl/crf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crf_pkg
// Shared widths, codes, payload types and the Horner rounding function
// for the complex rational function evaluator.
// ----------------------------------------------------------------------------
package crf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 24;
    // accumulator width: sum of two full products plus headroom
    localparam int ACC_BITS  = 2 * WORD_BITS + 2;
    localparam int DVD_BITS  = ACC_BITS + FRAC_BITS;
    localparam int CNT_BITS  = $clog2(DVD_BITS + 1);

    // MAC operation codes
    localparam logic [1:0] MAC_NOP  = 2'd0;
    localparam logic [1:0] MAC_LOAD = 2'd1;
    localparam logic [1:0] MAC_ADD  = 2'd2;
    localparam logic [1:0] MAC_SUB  = 2'd3;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [ACC_BITS-1:0]  t_acc;

    typedef struct packed {
        t_word point_re;
        t_word point_im;
        t_word coef_re;
        t_word coef_im;
        logic  to_denominator;
        logic  last;
    } t_in_req;

    typedef struct packed {
        t_word quot_re;
        t_word quot_im;
        logic  div_by_zero;
    } t_out_req;

    typedef struct packed {
        logic [1:0] op;
        t_word      a;
        t_word      b;
    } t_mac_ctl;

    // round product sum to nearest (ties up), add coefficient, saturate
    function automatic t_word horner_fin(t_acc prod, t_word coef);
        logic signed [ACC_BITS:0]             sum;
        logic signed [ACC_BITS-FRAC_BITS:0]   shr;
        logic signed [ACC_BITS-FRAC_BITS+1:0] tot;
        logic signed [ACC_BITS-FRAC_BITS+1:0] smax;
        logic signed [ACC_BITS-FRAC_BITS+1:0] smin;
        sum  = {prod[ACC_BITS-1], prod}
             + ((ACC_BITS+1)'(1) <<< (FRAC_BITS - 1));
        shr  = sum[ACC_BITS:FRAC_BITS];
        tot  = {shr[ACC_BITS-FRAC_BITS], shr}
             + (ACC_BITS-FRAC_BITS+2)'(coef);
        smax = (ACC_BITS-FRAC_BITS+2)'({1'b0, {(WORD_BITS-1){1'b1}}});
        smin = -smax - (ACC_BITS-FRAC_BITS+2)'(1);
        if (tot > smax) begin
            horner_fin = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (tot < smin) begin
            horner_fin = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            horner_fin = tot[WORD_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

### hw/rtl/complex_rational_function_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_rational_function_eval
// Horner evaluation of N(z) and D(z) on one shared MAC, then N/D through
// a shared restoring divider.
// A non-final request passes four products through the MAC pipeline.
// A final request then also uses the bit-serial divider (two quotients);
// a zero denominator skips the divider.
// Reset (synchronous, active low) clears both accumulators and all control.
// ----------------------------------------------------------------------------
module complex_rational_function_eval
    import crf_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  wire      i_req_valid,
    output logic     o_req_ready,
    input  t_in_req  i_req,
    output logic     o_rsp_valid,
    input  wire      i_rsp_ready,
    output t_out_req o_rsp
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HORN = 3'd1;
    localparam logic [2:0] ST_FIN  = 3'd2;
    localparam logic [2:0] ST_DRE  = 3'd3;
    localparam logic [2:0] ST_DIM  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]             r_state;
    logic [2:0]             r_step;
    t_in_req                r_item;
    t_word                  r_ar, r_ai;
    t_word                  r_nr, r_ni, r_dr, r_di;
    t_word                  r_new_re;
    logic [2*WORD_BITS-1:0] r_den;
    t_acc                   r_qre, r_qim;
    logic                   r_div_start;
    t_out_req               r_res;
    t_out_req               r_out;
    logic                   r_out_vld;

    t_mac_ctl               mac_ctl;
    t_acc                   mac_acc;
    logic                   div_done;
    t_word                  div_quot;
    t_word                  new_im;

    crf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .o_acc   (mac_acc)
    );

    crf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   ((r_state == ST_DIM) ? r_qim : r_qre),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;
    assign new_im      = horner_fin(mac_acc, r_item.coef_im);

    // MAC operand schedule
    always_comb begin
        mac_ctl = '{op: MAC_NOP, a: '0, b: '0};
        if (r_state == ST_HORN) begin
            case (r_step)
                3'd0: mac_ctl = '{op: MAC_LOAD, a: r_item.point_re, b: r_ar};
                3'd1: mac_ctl = '{op: MAC_SUB,  a: r_item.point_im, b: r_ai};
                3'd2: mac_ctl = '{op: MAC_LOAD, a: r_item.point_re, b: r_ai};
                3'd3: mac_ctl = '{op: MAC_ADD,  a: r_item.point_im, b: r_ar};
                default: mac_ctl = '{op: MAC_NOP, a: '0, b: '0};
            endcase
        end else if (r_state == ST_FIN) begin
            case (r_step)
                3'd0: mac_ctl = '{op: MAC_LOAD, a: r_dr, b: r_dr};
                3'd1: mac_ctl = '{op: MAC_ADD,  a: r_di, b: r_di};
                3'd2: mac_ctl = '{op: MAC_LOAD, a: r_nr, b: r_dr};
                3'd3: mac_ctl = '{op: MAC_ADD,  a: r_ni, b: r_di};
                3'd4: mac_ctl = '{op: MAC_LOAD, a: r_ni, b: r_dr};
                3'd5: mac_ctl = '{op: MAC_SUB,  a: r_nr, b: r_di};
                default: mac_ctl = '{op: MAC_NOP, a: '0, b: '0};
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_div_start <= 1'b0;
            r_out_vld   <= 1'b0;
            r_nr        <= '0;
            r_ni        <= '0;
            r_dr        <= '0;
            r_di        <= '0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_vld && i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_step <= '0;
                    if (i_req_valid) begin
                        r_item  <= i_req;
                        r_ar    <= i_req.to_denominator ? r_dr : r_nr;
                        r_ai    <= i_req.to_denominator ? r_di : r_ni;
                        r_state <= ST_HORN;
                    end
                end
                ST_HORN: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd3) begin
                        r_new_re <= horner_fin(mac_acc, r_item.coef_re);
                    end
                    if (r_step == 3'd5) begin
                        if (r_item.to_denominator) begin
                            r_dr <= r_new_re;
                            r_di <= new_im;
                        end else begin
                            r_nr <= r_new_re;
                            r_ni <= new_im;
                        end
                        r_step  <= '0;
                        r_state <= r_item.last ? ST_FIN : ST_IDLE;
                    end
                end
                ST_FIN: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd0 && r_dr == '0 && r_di == '0) begin
                        r_res   <= '{quot_re: '0, quot_im: '0, div_by_zero: 1'b1};
                        r_nr    <= '0;
                        r_ni    <= '0;
                        r_state <= ST_OUT;
                    end
                    if (r_step == 3'd3) begin
                        r_den <= mac_acc[2*WORD_BITS-1:0];
                    end
                    if (r_step == 3'd5) begin
                        r_qre <= mac_acc;
                    end
                    if (r_step == 3'd7) begin
                        r_qim       <= mac_acc;
                        r_nr        <= '0;
                        r_ni        <= '0;
                        r_dr        <= '0;
                        r_di        <= '0;
                        r_div_start <= 1'b1;
                        r_state     <= ST_DRE;
                    end
                end
                ST_DRE: begin
                    if (div_done) begin
                        r_res.quot_re     <= div_quot;
                        r_res.div_by_zero <= 1'b0;
                        r_div_start       <= 1'b1;
                        r_state           <= ST_DIM;
                    end
                end
                ST_DIM: begin
                    if (div_done) begin
                        r_res.quot_im <= div_quot;
                        r_state       <= ST_OUT;
                    end
                end
                // hand the result over once the output register is free
                ST_OUT: begin
                    r_dr <= '0;
                    r_di <= '0;
                    if (!r_out_vld || i_rsp_ready) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### hw/rtl/crf_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crf_mac
// Shared signed multiply-accumulate: registered product, then accumulate.
// An issued operation reaches o_acc through the product register and then the accumulator register.
// ----------------------------------------------------------------------------
module crf_mac
    import crf_pkg::*;
(
    input  wire      i_clk,
    input  wire      i_rst_n,
    input  t_mac_ctl i_ctl,
    output t_acc     o_acc
);

    logic [1:0]                     r_op;
    logic signed [2*WORD_BITS-1:0]  r_prod;
    t_acc                           r_acc;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= MAC_NOP;
        end else begin
            r_op <= i_ctl.op;
        end
        r_prod <= i_ctl.a * i_ctl.b;
    end

    // accumulate stage
    always_ff @(posedge i_clk) begin
        unique case (r_op)
            MAC_LOAD: r_acc <= t_acc'(r_prod);
            MAC_ADD:  r_acc <= r_acc + t_acc'(r_prod);
            MAC_SUB:  r_acc <= r_acc - t_acc'(r_prod);
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

### hw/rtl/crf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crf_div
// Radix-2 restoring divider: round(num * 2^FRAC / den), ties away from
// zero, saturated to a signed word. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module crf_div
    import crf_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  t_acc                       i_num,
    input  wire  [2*WORD_BITS-1:0]     i_den,
    output logic                       o_done,
    output t_word                      o_quot
);

    logic                    r_busy;
    logic                    r_fin;
    logic [CNT_BITS-1:0]     r_cnt;
    logic [DVD_BITS-1:0]     r_dvd;
    logic [2*WORD_BITS:0]    r_rem;
    logic [WORD_BITS:0]      r_q;
    logic                    r_big;
    logic                    r_neg;
    logic [2*WORD_BITS-1:0]  r_den;
    t_word                   r_quot;

    logic [2*WORD_BITS:0]    rs;
    logic                    ge;
    logic [WORD_BITS:0]      qs;
    logic                    rnd;
    logic [WORD_BITS:0]      qf;
    t_word                   quot;
    logic [ACC_BITS-1:0]     mag;

    // one restoring step
    always_comb begin
        rs = {r_rem[2*WORD_BITS-1:0], r_dvd[DVD_BITS-1]};
        ge = rs >= {1'b0, r_den};
        qs = {r_q[WORD_BITS-1:0], ge};
    end

    // rounding and saturation
    always_comb begin
        rnd = {r_rem, 1'b0} >= {2'b00, r_den};
        qf  = r_q + (WORD_BITS+1)'(rnd);
        if (r_neg) begin
            if (r_big || qf > (WORD_BITS+1)'({1'b1, {(WORD_BITS-1){1'b0}}})) begin
                quot = {1'b1, {(WORD_BITS-1){1'b0}}};
            end else begin
                quot = -qf[WORD_BITS-1:0];
            end
        end else begin
            if (r_big || qf > (WORD_BITS+1)'({1'b0, {(WORD_BITS-1){1'b1}}})) begin
                quot = {1'b0, {(WORD_BITS-1){1'b1}}};
            end else begin
                quot = qf[WORD_BITS-1:0];
            end
        end
    end

    assign mag = i_num[ACC_BITS-1] ? -i_num : i_num;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_fin;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_BITS'(1)) begin
                r_busy <= 1'b0;
                r_fin  <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= CNT_BITS'(DVD_BITS);
            r_dvd <= {mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
            r_big <= 1'b0;
            r_neg <= i_num[ACC_BITS-1];
            r_den <= i_den;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_BITS'(1);
            r_dvd <= {r_dvd[DVD_BITS-2:0], 1'b0};
            r_rem <= ge ? rs - {1'b0, r_den} : rs;
            if (!r_big) begin
                r_q <= qs;
                if (qs[WORD_BITS]) begin
                    r_big <= 1'b1;
                end
            end
        end
        if (r_fin) begin
            r_quot <= quot;
        end
    end

    assign o_quot = r_quot;

endmodule
`default_nettype wire

### verif/complex_rational_function_eval_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_rational_function_eval_tb
// Drives Horner coefficient streams into the evaluator with random gaps and
// back-pressure, predicts every quotient with wide integer math and checks
// each response field by field in arrival order.
// ----------------------------------------------------------------------------
module complex_rational_function_eval_tb;
    import crf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 400;

    typedef logic signed [127:0] t_wide;

    // Quotient predictor: own copy of both accumulators, queue of expected
    // responses, mismatch count.
    class quotient_board;
        t_word    num_re, num_im, den_re, den_im;
        t_out_req quot_q[$];
        int       errors;

        function new();
            clear_acc();
            errors = 0;
        endfunction

        function void clear_acc();
            num_re = '0;
            num_im = '0;
            den_re = '0;
            den_im = '0;
        endfunction

        function int pending();
            return quot_q.size();
        endfunction

        function t_word sat_word(t_wide v);
            t_wide hi_lim = (t_wide'(1) <<< (WORD_BITS - 1)) - 1;
            t_wide lo_lim = -(t_wide'(1) <<< (WORD_BITS - 1));
            if (v > hi_lim) return hi_lim[WORD_BITS-1:0];
            if (v < lo_lim) return lo_lim[WORD_BITS-1:0];
            return v[WORD_BITS-1:0];
        endfunction

        // acc = acc*z + c, product rounded half up, each part saturated
        function void horner_step(inout t_word acc_re, inout t_word acc_im,
                                  input t_word zr, input t_word zi,
                                  input t_word cr, input t_word ci);
            t_wide wzr = zr, wzi = zi, war = acc_re, wai = acc_im;
            t_wide wcr = cr, wci = ci;
            t_wide half = t_wide'(1) <<< (FRAC_BITS - 1);
            t_wide pr = wzr * war - wzi * wai;
            t_wide pi = wzr * wai + wzi * war;
            acc_re = sat_word(((pr + half) >>> FRAC_BITS) + wcr);
            acc_im = sat_word(((pi + half) >>> FRAC_BITS) + wci);
        endfunction

        // round(num * 2^F / den), ties away from zero, saturated
        function t_word divide_round(t_wide num, t_wide den);
            logic  neg = num < 0;
            t_wide mag = neg ? -num : num;
            t_wide dvd = mag <<< FRAC_BITS;
            t_wide q   = dvd / den;
            t_wide rm  = dvd % den;
            if (2 * rm >= den) q = q + 1;
            return sat_word(neg ? -q : q);
        endfunction

        function void note_request(t_in_req r);
            t_out_req exp_rsp;
            t_wide nr, ni, dr, di, mag;
            if (r.to_denominator)
                horner_step(den_re, den_im, r.point_re, r.point_im, r.coef_re, r.coef_im);
            else
                horner_step(num_re, num_im, r.point_re, r.point_im, r.coef_re, r.coef_im);
            if (!r.last) return;
            nr = num_re; ni = num_im; dr = den_re; di = den_im;
            clear_acc();
            if (dr == 0 && di == 0) begin
                exp_rsp = '{quot_re: '0, quot_im: '0, div_by_zero: 1'b1};
            end else begin
                mag = dr * dr + di * di;
                exp_rsp.quot_re     = divide_round(nr * dr + ni * di, mag);
                exp_rsp.quot_im     = divide_round(ni * dr - nr * di, mag);
                exp_rsp.div_by_zero = 1'b0;
            end
            quot_q.push_back(exp_rsp);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_result(t_out_req got);
            t_out_req want;
            if (quot_q.size() == 0) begin
                report($sformatf("unexpected response %h", got));
                return;
            end
            want = quot_q.pop_front();
            if (got.quot_re !== want.quot_re)
                report($sformatf("quot_re got %h want %h", got.quot_re, want.quot_re));
            if (got.quot_im !== want.quot_im)
                report($sformatf("quot_im got %h want %h", got.quot_im, want.quot_im));
            if (got.div_by_zero !== want.div_by_zero)
                report($sformatf("div_by_zero got %b want %b",
                                 got.div_by_zero, want.div_by_zero));
        endtask
    endclass

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_req_valid = 1'b0;
    logic     o_req_ready;
    t_in_req  i_req = '0;
    logic     o_rsp_valid;
    logic     i_rsp_ready = 1'b0;
    t_out_req o_rsp;

    quotient_board board = new();
    int  send_idle_pct = 14;
    int  rsp_idle_pct  = 14;
    int  cycles = 0;
    int  sent = 0;

    complex_rational_function_eval DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // cycle watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // response side: random stalls, check on every accepted response
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            board.check_result(o_rsp);
        i_rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // one request through the handshake; called right after a rising edge
    task automatic send_req(t_in_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            i_req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_req_valid <= 1'b1;
        i_req       <= r;
        do @(posedge i_clk); while (!o_req_ready);
        board.note_request(r);
        sent++;
    endtask

    function automatic t_word pick_val(bit small_only);
        int sel = small_only ? 0 : $urandom_range(9);
        case (sel)
            0, 1, 2, 3, 4: return t_word'($signed($urandom_range(1 << 26)) - (1 << 25));
            5, 6:          return t_word'($urandom);
            7:             return {1'b0, {(WORD_BITS-1){1'b1}}};
            8:             return {1'b1, {(WORD_BITS-1){1'b0}}};
            default:       return t_word'($signed($urandom_range(8)) - 4);
        endcase
    endfunction

    // one evaluation: interleaved numerator/denominator coefficients
    task automatic run_eval(int n_num, int n_den, bit move_point, bit tame);
        t_in_req r;
        t_word zr = pick_val(tame), zi = pick_val(tame);
        int left = n_num + n_den;
        if (left == 0) begin
            n_den = 1;
            left = 1;
        end
        while (left > 0) begin
            if (move_point) begin
                zr = pick_val(tame);
                zi = pick_val(tame);
            end
            r.point_re = zr;
            r.point_im = zi;
            r.coef_re  = pick_val(tame && $urandom_range(3) != 0);
            r.coef_im  = pick_val(tame && $urandom_range(3) != 0);
            if (n_num == 0) r.to_denominator = 1'b1;
            else if (n_den == 0) r.to_denominator = 1'b0;
            else r.to_denominator = $urandom_range(n_num + n_den - 1) >= n_num;
            if (r.to_denominator) n_den--; else n_num--;
            left--;
            r.last = (left == 0);
            send_req(r);
        end
    endtask

    // sender stays quiet until every expected response has come back
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_word wmax = {1'b0, {(WORD_BITS-1){1'b1}}};
        t_word wmin = {1'b1, {(WORD_BITS-1){1'b0}}};
        t_word one  = t_word'(1) <<< FRAC_BITS;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty denominator gives the zero-denominator flag
        send_req('{one, '0, one, one, 1'b0, 1'b1});
        // empty numerator over a constant denominator
        send_req('{one, one, one, '0, 1'b1, 1'b1});
        // unit numerator over unit denominator
        send_req('{one, '0, one, '0, 1'b0, 1'b0});
        send_req('{one, '0, one, '0, 1'b1, 1'b1});
        // denominator that cancels to exact zero: (z - 1) at z = 1
        send_req('{one, '0, one, '0, 1'b0, 1'b0});
        send_req('{one, '0, one, '0, 1'b1, 1'b0});
        send_req('{one, '0, -one, '0, 1'b1, 1'b1});
        // extremes, saturating Horner and quotient
        send_req('{wmax, wmax, wmax, wmax, 1'b0, 1'b0});
        send_req('{wmax, wmax, wmax, wmax, 1'b0, 1'b0});
        send_req('{wmin, wmin, 32'sd1, 32'sd1, 1'b1, 1'b1});
        send_req('{wmin, wmin, wmin, wmin, 1'b0, 1'b0});
        send_req('{wmin, wmax, wmin, wmin, 1'b0, 1'b0});
        send_req('{wmax, wmin, wmax, wmin, 1'b1, 1'b1});
        // tiny denominator, huge numerator
        send_req('{'0, '0, wmin, wmax, 1'b0, 1'b0});
        send_req('{'0, '0, 32'sd1, -32'sd1, 1'b1, 1'b1});
        // point changes within an evaluation
        send_req('{one, one, one, '0, 1'b0, 1'b0});
        send_req('{-one, one, '0, one, 1'b0, 1'b0});
        send_req('{one >>> 1, -one, one, one, 1'b1, 1'b1});
        // rounding ties: half-LSB products
        send_req('{t_word'(1) <<< (FRAC_BITS - 1), '0, one, '0, 1'b0, 1'b0});
        send_req('{32'sd1, '0, '0, '0, 1'b0, 1'b0});
        send_req('{'0, '0, 32'sd3, '0, 1'b1, 1'b1});

        // random evaluations; a calm stretch with no idling in the middle
        while (sent < 500) begin
            if (sent > 200 && sent < 300) begin
                send_idle_pct = 0;
                rsp_idle_pct  = 0;
            end else begin
                send_idle_pct = 14;
                rsp_idle_pct  = 14;
            end
            if (sent > 350 && sent < 360) wait_drained();
            if ($urandom_range(9) < 8)
                run_eval($urandom_range(4), $urandom_range(4), 1'b0, $urandom_range(3) != 0);
            else
                run_eval($urandom_range(3), $urandom_range(3), 1'b1, 1'b0);
        end
        i_req_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
